/* hdl/mfa_pkg.sv */
// Shared constants and types for the max-flow block.
`timescale 1ns / 1ps
`default_nettype none
package mfa_pkg;
	localparam int MAX_NODES_DEF = 64;
	localparam int CAP_BITS_DEF  = 16;
	localparam int TOTAL_BITS    = 22;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 7;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SINK   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NCOUNT = 2'd2;

	// search -> edge store requests
	typedef struct packed {
		logic flow_we;
		logic clear;
	} srch_cmd_t;

	// full edge store command
	typedef struct packed {
		logic cap_we;
		logic flow_we;
		logic clear;
	} mem_cmd_t;
endpackage
`default_nettype wire

/* hdl/mfa_edge_mem.sv */
// Capacity and flow stores indexed by node pair, with a clearing sweep.
`timescale 1ns / 1ps
`default_nettype none
module mfa_edge_mem import mfa_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int CAP_BITS  = CAP_BITS_DEF,
	localparam int DEPTH  = MAX_NODES * MAX_NODES,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mem_cmd_t          cmd,
	input  wire logic [ADDR_W-1:0] cap_waddr,
	input  wire logic [CAP_BITS-1:0] cap_wdata,
	input  wire logic [ADDR_W-1:0] flow_waddr,
	input  wire logic [CAP_BITS-1:0] flow_wdata,
	input  wire logic [ADDR_W-1:0] rd_addr_a,
	input  wire logic [ADDR_W-1:0] rd_addr_b,
	output logic [CAP_BITS-1:0]    cap_rdata,
	output logic [CAP_BITS-1:0]    flow_rdata_a,
	output logic [CAP_BITS-1:0]    flow_rdata_b,
	output logic                   clearing
);
	logic [CAP_BITS-1:0] cap_mem [DEPTH];
	logic [CAP_BITS-1:0] flow_mem [DEPTH];
	logic                clr_q;
	logic [ADDR_W-1:0]   clr_cnt_q;

	// sweep runs after reset and after every result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end else if (cmd.clear) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			cap_mem[clr_cnt_q]  <= '0;
			flow_mem[clr_cnt_q] <= '0;
		end else begin
			if (cmd.cap_we) begin
				cap_mem[cap_waddr] <= cap_wdata;
			end
			if (cmd.flow_we) begin
				flow_mem[flow_waddr] <= flow_wdata;
			end
		end
		cap_rdata    <= cap_mem[rd_addr_a];
		flow_rdata_a <= flow_mem[rd_addr_a];
		flow_rdata_b <= flow_mem[rd_addr_b];
	end

	assign clearing = clr_q;
endmodule
`default_nettype wire

/* hdl/mfa_search.sv */
// Depth-first path search, bottleneck walk and augmentation sequencer.
`timescale 1ns / 1ps
`default_nettype none
module mfa_search import mfa_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int CAP_BITS  = CAP_BITS_DEF,
	localparam int NB     = $clog2(MAX_NODES),
	localparam int ADDR_W = $clog2(MAX_NODES * MAX_NODES)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                go,
	input  wire logic                go_bad,
	input  wire logic [NB-1:0]       src,
	input  wire logic [NB-1:0]       snk,
	input  wire logic [NB:0]         limit,
	input  wire logic [CAP_BITS-1:0] cap_rdata,
	input  wire logic [CAP_BITS-1:0] flow_rdata_a,
	input  wire logic [CAP_BITS-1:0] flow_rdata_b,
	output logic [ADDR_W-1:0]        rd_addr_a,
	output logic [ADDR_W-1:0]        rd_addr_b,
	output logic [ADDR_W-1:0]        flow_waddr,
	output logic [CAP_BITS-1:0]      flow_wdata,
	output srch_cmd_t                cmd,
	output logic                     busy,
	output logic                     done,
	output logic [TOTAL_BITS-1:0]    max_flow
);
	typedef enum logic [3:0] {
		S_IDLE, S_NEXT, S_SCAN, S_EVAL, S_POP, S_POPW,
		S_A1P, S_A1R, S_A1E, S_A2P, S_A2R, S_A2W1, S_A2W2, S_DONE
	} state_t;

	localparam int SW = NB + NB + 1;

	function automatic logic [ADDR_W-1:0] idx(input logic [NB-1:0] a, input logic [NB-1:0] b);
		idx = ADDR_W'(int'(a) * MAX_NODES + int'(b));
	endfunction

	state_t                state_q;
	logic [NB-1:0]         cur_u_q;
	logic [NB:0]           cur_v_q;
	logic [NB-1:0]         sp_q;
	logic [NB-1:0]         vw_q;
	logic [NB-1:0]         uw_q;
	logic [CAP_BITS:0]     bott_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [CAP_BITS-1:0]   fnew_q;
	logic [MAX_NODES-1:0]  visited_q;

	logic [NB-1:0] par_mem [MAX_NODES];
	logic [SW-1:0] stk_mem [MAX_NODES];
	logic [NB-1:0] par_rd_q;
	logic [SW-1:0] stk_rd_q;

	logic [NB-1:0]       rd_u, rd_v, cv;
	logic [CAP_BITS+1:0] resid_w;
	logic [CAP_BITS:0]   resid;
	logic [CAP_BITS:0]   cancel;
	logic [CAP_BITS+1:0] fnew_w;
	logic [CAP_BITS:0]   back_left;
	logic [32:0]         tsum;

	assign cv = cur_v_q[NB-1:0];

	always_comb begin
		if (state_q == S_A1R || state_q == S_A2R) begin
			rd_u = par_rd_q;
			rd_v = vw_q;
		end else begin
			rd_u = cur_u_q;
			rd_v = cv;
		end
	end

	assign rd_addr_a = idx(rd_u, rd_v);
	assign rd_addr_b = idx(rd_v, rd_u);

	// residual u->v = cap(u,v) - flow(u,v) + flow(v,u)
	assign resid_w = {2'b00, cap_rdata} - {2'b00, flow_rdata_a} + {2'b00, flow_rdata_b};
	assign resid   = resid_w[CAP_BITS:0];

	assign cancel    = ({1'b0, flow_rdata_b} < bott_q) ? {1'b0, flow_rdata_b} : bott_q;
	assign back_left = {1'b0, flow_rdata_b} - cancel;
	assign fnew_w    = {2'b00, flow_rdata_a} + {1'b0, bott_q} - {1'b0, cancel};
	assign tsum      = 33'(total_q) + 33'(bott_q);

	assign flow_waddr  = (state_q == S_A2W1) ? idx(vw_q, uw_q) : idx(uw_q, vw_q);
	assign flow_wdata  = (state_q == S_A2W1) ? back_left[CAP_BITS-1:0] : fnew_q;
	assign cmd.flow_we = (state_q == S_A2W1) || (state_q == S_A2W2);
	assign cmd.clear   = (state_q == S_DONE);
	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_DONE);
	assign max_flow    = total_q;

	always_ff @(posedge clk) begin
		par_rd_q <= par_mem[vw_q];
		stk_rd_q <= stk_mem[sp_q - 1'b1];
		if (state_q == S_EVAL && resid_w != '0) begin
			par_mem[cv]   <= cur_u_q;
			stk_mem[sp_q] <= {cur_u_q, cur_v_q + 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_u_q   <= '0;
			cur_v_q   <= '0;
			sp_q      <= '0;
			vw_q      <= '0;
			uw_q      <= '0;
			bott_q    <= '1;
			total_q   <= '0;
			fnew_q    <= '0;
			visited_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (go) begin
						total_q <= '0;
						state_q <= go_bad ? S_DONE : S_NEXT;
					end
				end
				S_NEXT: begin
					// only the source starts out marked
					visited_q <= MAX_NODES'(1) << src;
					cur_u_q   <= src;
					cur_v_q   <= '0;
					sp_q      <= '0;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					if (cur_v_q >= limit) begin
						state_q <= S_POP;
					end else if (visited_q[cv]) begin
						cur_v_q <= cur_v_q + 1'b1;
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (resid_w != '0) begin
						visited_q[cv] <= 1'b1;
						sp_q          <= sp_q + 1'b1;
						cur_u_q       <= cv;
						cur_v_q       <= '0;
						if (cv == snk) begin
							bott_q  <= '1;
							vw_q    <= snk;
							state_q <= S_A1P;
						end else begin
							state_q <= S_SCAN;
						end
					end else begin
						cur_v_q <= cur_v_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_DONE;
					end else begin
						sp_q    <= sp_q - 1'b1;
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					cur_u_q <= stk_rd_q[SW-1 -: NB];
					cur_v_q <= stk_rd_q[NB:0];
					state_q <= S_SCAN;
				end
				S_A1P: state_q <= S_A1R;
				S_A1R: begin
					uw_q    <= par_rd_q;
					state_q <= S_A1E;
				end
				S_A1E: begin
					if (resid < bott_q) begin
						bott_q <= resid;
					end
					if (uw_q == src) begin
						vw_q    <= snk;
						state_q <= S_A2P;
					end else begin
						vw_q    <= uw_q;
						state_q <= S_A1P;
					end
				end
				S_A2P: state_q <= S_A2R;
				S_A2R: begin
					uw_q    <= par_rd_q;
					state_q <= S_A2W1;
				end
				S_A2W1: begin
					fnew_q  <= fnew_w[CAP_BITS-1:0];
					state_q <= S_A2W2;
				end
				S_A2W2: begin
					vw_q <= uw_q;
					if (uw_q == src) begin
						total_q <= (tsum > 33'(TOTAL_MAX)) ? TOTAL_MAX : tsum[TOTAL_BITS-1:0];
						state_q <= S_NEXT;
					end else begin
						state_q <= S_A2P;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/max_flow_dfs_augment.sv */
// Top level: edge loading, configuration registers and max-flow engine. An edge item is
// written when accepted; a last item's result follows its search: a visited neighbor takes
// S_SCAN, another S_SCAN then S_EVAL; a pop S_POP then S_POPW; a path edge augmented S_A1P/R/E,
// then S_A2P/R/W1/W2. Throughput: one edge item per cycle while busy is low; after each result
// the stores are swept clean, all MAX_NODES*MAX_NODES entries (4096 by default), busy high.
// Reset: source 0, sink 1, node count 64, then the same sweep; done lasts one cycle, no stall.
`timescale 1ns / 1ps
`default_nettype none
module max_flow_dfs_augment import mfa_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int CAP_BITS  = CAP_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [5:0]               from_node,
	input  wire logic [5:0]               to_node,
	input  wire logic [15:0]              capacity,
	input  wire logic                     last_edge,
	output logic                          done,
	output logic [TOTAL_BITS-1:0]         max_flow,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);
	localparam int NB     = $clog2(MAX_NODES);
	localparam int ADDR_W = $clog2(MAX_NODES * MAX_NODES);

	// configuration registers
	logic [5:0] source_q;
	logic [5:0] sink_q;
	logic [6:0] ncount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= 6'd0;
			sink_q   <= 6'd1;
			ncount_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SOURCE: source_q <= cfg_data[5:0];
				CFG_SINK:   sink_q   <= cfg_data[5:0];
				CFG_NCOUNT: ncount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic            accept, edge_ok, go_bad, srch_busy, clearing;
	logic [NB:0]     limit;
	mem_cmd_t        mcmd;
	srch_cmd_t       scmd;
	logic [ADDR_W-1:0]   rd_a, rd_b, flow_waddr, cap_waddr;
	logic [CAP_BITS-1:0] flow_wdata, cap_rd, flow_rd_a, flow_rd_b;

	// an item is taken only when neither search nor sweep is running
	assign busy   = srch_busy | clearing;
	assign accept = start & ~busy;

	// edges naming a node beyond the store are dropped
	assign edge_ok   = (int'(from_node) < MAX_NODES) && (int'(to_node) < MAX_NODES);
	assign cap_waddr = ADDR_W'(int'(from_node) * MAX_NODES + int'(to_node));

	// out-of-range or equal terminals give a zero result right away
	assign go_bad = !((int'(source_q) < MAX_NODES) && (int'(sink_q) < MAX_NODES)
		&& (source_q != sink_q));
	assign limit  = (int'(ncount_q) > MAX_NODES) ? (NB+1)'(MAX_NODES) : (NB+1)'(ncount_q);

	assign mcmd.cap_we  = accept & edge_ok;
	assign mcmd.flow_we = scmd.flow_we;
	assign mcmd.clear   = scmd.clear;

	mfa_edge_mem #(
		.MAX_NODES(MAX_NODES),
		.CAP_BITS (CAP_BITS)
	) u_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (mcmd),
		.cap_waddr   (cap_waddr),
		.cap_wdata   (CAP_BITS'(capacity)),
		.flow_waddr  (flow_waddr),
		.flow_wdata  (flow_wdata),
		.rd_addr_a   (rd_a),
		.rd_addr_b   (rd_b),
		.cap_rdata   (cap_rd),
		.flow_rdata_a(flow_rd_a),
		.flow_rdata_b(flow_rd_b),
		.clearing    (clearing)
	);

	mfa_search #(
		.MAX_NODES(MAX_NODES),
		.CAP_BITS (CAP_BITS)
	) u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (accept & last_edge),
		.go_bad      (go_bad),
		.src         (NB'(source_q)),
		.snk         (NB'(sink_q)),
		.limit       (limit),
		.cap_rdata   (cap_rd),
		.flow_rdata_a(flow_rd_a),
		.flow_rdata_b(flow_rd_b),
		.rd_addr_a   (rd_a),
		.rd_addr_b   (rd_b),
		.flow_waddr  (flow_waddr),
		.flow_wdata  (flow_wdata),
		.cmd         (scmd),
		.busy        (srch_busy),
		.done        (done),
		.max_flow    (max_flow)
	);

`ifndef ASSERT_OFF
	// every result is followed by the store sweep
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> clearing) else $error("no sweep after result");
	// no edge is loaded while the stores are being cleared
	a_no_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mcmd.cap_we |-> !clearing) else $error("edge load during sweep");
	// flow updates only happen while a search is active
	a_flow_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		mcmd.flow_we |-> (srch_busy && !clearing)) else $error("stray flow write");
	// result strobe is a single pulse
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe too long");
`endif
endmodule
`default_nettype wire
